### hw/rtl/swcs_pkg.sv
// swcs_pkg: shared types and codes for the stop-and-wait command sender
// no dependencies; imported by every module of the block
`default_nettype none

package swcs_pkg;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_CLOSE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    EV_SEND    = 3'd0,
    EV_ACKED   = 3'd1,
    EV_GAVE_UP = 3'd2,
    EV_RETRY   = 3'd3,
    EV_DROPPED = 3'd4
  } event_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd1;

  localparam logic [15:0] TIMEOUT_RESET      = 16'd500;
  localparam logic [3:0]  MAX_ATTEMPTS_RESET = 4'd3;

  // small queues on either side of the engine
  localparam int INQ_DEPTH  = 2;
  localparam int RESQ_DEPTH = 4;

  typedef enum logic {
    PH_FIRST  = 1'b0,
    PH_SECOND = 1'b1
  } phase_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] cmd;
    logic [7:0] param;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_slot_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] cmd;
    logic [7:0] param;
    logic [3:0] attempt;
    logic [4:0] pending;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } res_push_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [3:0]  max_attempts;
  } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/stop_wait_command_sender.sv
// stop_wait_command_sender: top level, configuration registers and wiring
// depends on swcs_pkg, swcs_front, swcs_engine, swcs_resq
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | push / full          | action, cmd, param
//   result   | pop / empty          | event_res, out_cmd, out_param, attempt,
//            |                      | pending, last
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// each item passes the engine states PH_FIRST, for its event, and PH_SECOND,
// for the frame send that may follow; the engine starts no item in PH_SECOND
// results pass through the result queue and reach the ports registered
// a two-entry input queue takes items while the engine works; the engine starts an
// item only while the four-entry result queue has room for two
// rst is synchronous; both queues, the fifo pointers and the sender state clear
`default_nettype none

module stop_wait_command_sender #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    action,
  input  wire logic [7:0]                    cmd,
  input  wire logic [7:0]                    param,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [2:0]                         event_res,
  output logic [7:0]                         out_cmd,
  output logic [7:0]                         out_param,
  output logic [3:0]                         attempt,
  output logic [4:0]                         pending,
  output logic                               last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [swcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import swcs_pkg::*;

  cfg_t       cfg;
  item_t      item_in;
  item_slot_t inq_head;
  logic       take;
  logic       room2;
  res_push_t  res_push;
  result_t    res_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_RESET;
      cfg.max_attempts  <= MAX_ATTEMPTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TIMEOUT) begin
        cfg.timeout_ticks <= cfg_data;
      end else if (cfg_index == REG_MAX_ATTEMPTS) begin
        cfg.max_attempts <= cfg_data[3:0];
      end
    end
  end

  assign item_in.action = action_t'(action);
  assign item_in.cmd    = cmd;
  assign item_in.param  = param;

  swcs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item_in (item_in),
    .take    (take),
    .head    (inq_head)
  );

  swcs_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (inq_head),
    .take  (take),
    .room2 (room2),
    .res_o (res_push)
  );

  swcs_resq u_resq (
    .clk   (clk),
    .rst   (rst),
    .res_i (res_push),
    .room2 (room2),
    .pop   (pop),
    .empty (empty),
    .head  (res_head)
  );

  assign event_res = res_head.ev;
  assign out_cmd   = res_head.cmd;
  assign out_param = res_head.param;
  assign attempt   = res_head.attempt;
  assign pending   = res_head.pending;
  assign last      = res_head.last;

endmodule

`default_nettype wire

### hw/rtl/swcs_front.sv
// swcs_front: input queue that takes items and holds them for the engine
// depends on swcs_pkg
`default_nettype none

module swcs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire swcs_pkg::item_t item_in,
  input  wire logic          take,
  output swcs_pkg::item_slot_t head
);
  import swcs_pkg::*;

  localparam int PW = (INQ_DEPTH > 1) ? $clog2(INQ_DEPTH) : 1;
  localparam int CW = $clog2(INQ_DEPTH + 1);

  item_t           slots [INQ_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(INQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = take && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(INQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(INQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/swcs_engine.sv
// swcs_engine: sender state, command fifo memory and retry countdown
// depends on swcs_pkg; takes items from swcs_front, feeds swcs_resq
`default_nettype none

module swcs_engine #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire swcs_pkg::cfg_t       cfg,
  input  wire swcs_pkg::item_slot_t head,
  output logic                      take,
  input  wire logic                 room2,
  output swcs_pkg::res_push_t       res_o
);
  import swcs_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = (FW + 1 > 5) ? FW + 1 : 5;

  function automatic logic [4:0] pend(input logic [FW-1:0] f, input logic a);
    logic [SW-1:0] s;
    s = SW'(f) + SW'(a);
    return s[4:0];
  endfunction

  logic [15:0]   mem [QUEUE_DEPTH];
  logic [15:0]   rd_data;

  phase_t        state, state_next;
  logic [AW-1:0] rptr, rptr_next;
  logic [AW-1:0] wptr, wptr_next;
  logic [FW-1:0] fill, fill_next;
  logic [7:0]    cur_cmd, cur_cmd_next;
  logic [7:0]    cur_param, cur_param_next;
  logic          awaiting, awaiting_next;
  logic [3:0]    retries, retries_next;
  logic [15:0]   countdown, countdown_next;
  logic          disp, disp_next;
  logic          resend, resend_next;
  logic          bypass, bypass_next;
  logic [7:0]    byp_cmd, byp_param;
  logic          start;
  logic          wr_en;
  logic          full_q;
  logic [3:0]    retries_inc;
  logic          give_up;
  logic [7:0]    disp_cmd, disp_param;

  assign start       = (state == PH_FIRST) && head.valid && room2;
  assign take        = start;
  assign full_q      = (fill >= FW'(QUEUE_DEPTH));
  assign retries_inc = retries + 4'd1;
  assign give_up     = (retries_inc >= cfg.max_attempts) || (retries_inc == 4'd0);
  assign disp_cmd    = bypass ? byp_cmd : rd_data[15:8];
  assign disp_param  = bypass ? byp_param : rd_data[7:0];

  always_comb begin
    state_next = state;
    unique case (state)
      PH_FIRST:  if (start) state_next = PH_SECOND;
      PH_SECOND: state_next = PH_FIRST;
      default:   state_next = PH_FIRST;
    endcase
  end

  always_comb begin
    rptr_next      = rptr;
    wptr_next      = wptr;
    fill_next      = fill;
    cur_cmd_next   = cur_cmd;
    cur_param_next = cur_param;
    awaiting_next  = awaiting;
    retries_next   = retries;
    countdown_next = countdown;
    disp_next      = disp;
    resend_next    = resend;
    bypass_next    = bypass;
    wr_en          = 1'b0;
    res_o          = '0;

    if (start) begin
      disp_next   = 1'b0;
      resend_next = 1'b0;
      bypass_next = 1'b0;
      unique case (head.item.action)
        ACT_ENQUEUE: begin
          if (full_q) begin
            res_o.push        = 1'b1;
            res_o.res.ev      = EV_DROPPED;
            res_o.res.cmd     = head.item.cmd;
            res_o.res.param   = head.item.param;
            res_o.res.pending = pend(fill, awaiting);
            res_o.res.last    = awaiting;
          end else begin
            wr_en       = 1'b1;
            wptr_next   = (wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
            fill_next   = fill + 1'b1;
            // an empty fifo hands the new command straight through
            bypass_next = (fill == '0);
          end
          disp_next = !awaiting;
        end
        ACT_ACK: begin
          if (awaiting && head.item.cmd == cur_cmd) begin
            awaiting_next     = 1'b0;
            countdown_next    = '0;
            res_o.push        = 1'b1;
            res_o.res.ev      = EV_ACKED;
            res_o.res.cmd     = head.item.cmd;
            res_o.res.param   = head.item.param;
            res_o.res.pending = pend(fill, 1'b0);
            res_o.res.last    = (fill == '0);
            disp_next         = (fill != '0);
          end
        end
        ACT_TICK: begin
          if (awaiting) begin
            if (countdown > 16'd1) begin
              countdown_next = countdown - 16'd1;
            end else begin
              countdown_next  = '0;
              retries_next    = retries_inc;
              res_o.push      = 1'b1;
              res_o.res.cmd   = cur_cmd;
              res_o.res.param = cur_param;
              if (give_up) begin
                awaiting_next     = 1'b0;
                res_o.res.ev      = EV_GAVE_UP;
                res_o.res.pending = pend(fill, 1'b0);
                res_o.res.last    = (fill == '0);
                disp_next         = (fill != '0);
              end else begin
                res_o.res.ev      = EV_RETRY;
                res_o.res.attempt = retries_inc + 4'd1;
                res_o.res.pending = pend(fill, 1'b1);
                res_o.res.last    = 1'b0;
                resend_next       = 1'b1;
              end
            end
          end
        end
        ACT_CLOSE: begin
          rptr_next      = '0;
          wptr_next      = '0;
          fill_next      = '0;
          awaiting_next  = 1'b0;
          countdown_next = '0;
        end
        default: ;
      endcase
    end else if (state == PH_SECOND) begin
      if (disp) begin
        rptr_next         = (rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
        fill_next         = fill - 1'b1;
        cur_cmd_next      = disp_cmd;
        cur_param_next    = disp_param;
        retries_next      = '0;
        awaiting_next     = 1'b1;
        countdown_next    = cfg.timeout_ticks;
        res_o.push        = 1'b1;
        res_o.res.ev      = EV_SEND;
        res_o.res.cmd     = disp_cmd;
        res_o.res.param   = disp_param;
        res_o.res.pending = pend(fill, 1'b0);
        res_o.res.last    = 1'b1;
      end else if (resend) begin
        countdown_next    = cfg.timeout_ticks;
        res_o.push        = 1'b1;
        res_o.res.ev      = EV_SEND;
        res_o.res.cmd     = cur_cmd;
        res_o.res.param   = cur_param;
        res_o.res.pending = pend(fill, 1'b1);
        res_o.res.last    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PH_FIRST;
      rptr      <= '0;
      wptr      <= '0;
      fill      <= '0;
      cur_cmd   <= '0;
      cur_param <= '0;
      awaiting  <= 1'b0;
      retries   <= '0;
      countdown <= '0;
      disp      <= 1'b0;
      resend    <= 1'b0;
      bypass    <= 1'b0;
    end else begin
      state     <= state_next;
      rptr      <= rptr_next;
      wptr      <= wptr_next;
      fill      <= fill_next;
      cur_cmd   <= cur_cmd_next;
      cur_param <= cur_param_next;
      awaiting  <= awaiting_next;
      retries   <= retries_next;
      countdown <= countdown_next;
      disp      <= disp_next;
      resend    <= resend_next;
      bypass    <= bypass_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      byp_cmd   <= head.item.cmd;
      byp_param <= head.item.param;
    end
  end

  // command fifo: one write, one PH_FIRST registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= {head.item.cmd, head.item.param};
    end
    if (state == PH_FIRST) begin
      rd_data <= mem[rptr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/swcs_resq.sv
// swcs_resq: result queue between the engine and the result ports
// depends on swcs_pkg
`default_nettype none

module swcs_resq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire swcs_pkg::res_push_t res_i,
  output logic                     room2,
  input  wire logic                pop,
  output logic                     empty,
  output swcs_pkg::result_t        head
);
  import swcs_pkg::*;

  localparam int PW = $clog2(RESQ_DEPTH);
  localparam int CW = $clog2(RESQ_DEPTH + 1);

  result_t       slots [RESQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  // room for both results of one item
  assign room2  = (count <= CW'(RESQ_DEPTH - 2));
  assign head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_i.push) begin
        wr_ptr <= (wr_ptr == PW'(RESQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(RESQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({res_i.push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_i.push) begin
      slots[wr_ptr] <= res_i.res;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/swcs_checker.sv
// swcs_checker: port-level checks on the result channel of the sender
// depends on swcs_pkg; bound to stop_wait_command_sender below
`default_nettype none

module swcs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [2:0] event_res,
  input wire logic [7:0] out_cmd,
  input wire logic [3:0] attempt,
  input wire logic       last
);
  import swcs_pkg::*;

  // reset leaves nothing to pop
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // attempt number only on retry notices
  a_attempt_retry: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_res != EV_RETRY) |-> attempt == 4'd0)
    else $error("attempt set on a non-retry result");

  // a retry notice is always followed by the resend of the same command
  a_retry_then_send: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && event_res == EV_RETRY) |=>
      (!empty && event_res == EV_SEND && out_cmd == $past(out_cmd)))
    else $error("retry notice not followed by its resend");

  a_retry_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_res == EV_RETRY) |-> !last)
    else $error("retry notice marked as final transaction");

  // a waiting transaction holds while pop is low
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(event_res) && $stable(out_cmd)))
    else $error("result changed while stalled");

endmodule

bind stop_wait_command_sender swcs_checker u_swcs_checker (
  .clk       (clk),
  .rst       (rst),
  .empty     (empty),
  .pop       (pop),
  .event_res (event_res),
  .out_cmd   (out_cmd),
  .attempt   (attempt),
  .last      (last)
);

`default_nettype wire

### test/stop_wait_command_sender_tb.sv
// stop_wait_command_sender_tb: self-checking bench for the stop-and-wait command sender
// depends on swcs_pkg and stop_wait_command_sender; results are checked against an
// in-bench model of the command queue, the in-flight command and its retry timer
`timescale 1ns / 100ps

module stop_wait_command_sender_tb;
  import swcs_pkg::*;

  localparam int QDEPTH         = 16;
  localparam int NUM_PHASES     = 6;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 20;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  logic                 full;
  logic [1:0]           action    = ACT_ENQUEUE;
  logic [7:0]           cmd       = '0;
  logic [7:0]           param     = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  logic [2:0]           event_res;
  logic [7:0]           out_cmd;
  logic [7:0]           out_param;
  logic [3:0]           attempt;
  logic [4:0]           pending;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TIMEOUT;
  logic [15:0]          cfg_data  = '0;

  // register settings of the random phases, extremes included
  int ph_timeout[NUM_PHASES]  = '{3, 0, 1, 65535, 2, 7};
  int ph_attempts[NUM_PHASES] = '{3, 0, 15, 15, 1, 5};
  int ph_items[NUM_PHASES]    = '{200, 150, 220, 150, 150, 180};
  int ph_enq[NUM_PHASES]      = '{45, 35, 10, 40, 30, 35};
  int ph_ack[NUM_PHASES]      = '{30, 25, 8, 40, 20, 25};
  int ph_tick[NUM_PHASES]     = '{23, 38, 80, 18, 48, 38};

  // model of the sender
  logic [15:0] cfg_timeout  = TIMEOUT_RESET;
  logic [3:0]  cfg_attempts = MAX_ATTEMPTS_RESET;
  logic [15:0] waiting_cmds[$];
  logic        in_flight    = 1'b0;
  logic [7:0]  fl_opcode    = '0;
  logic [7:0]  fl_param     = '0;
  logic [3:0]  sends_done   = '0;
  logic [15:0] ticks_left   = '0;
  int          n_new;
  result_t     due_events[$];

  item_t       pending_items[$];
  logic [7:0]  gen_order[$];
  logic [7:0]  op_pool[4];
  int          n_queued      = 0;
  int          n_accepted    = 0;
  int          n_checked     = 0;
  int          n_errors      = 0;
  int          n_full_cycles = 0;
  int          n_ev[5]       = '{0, 0, 0, 0, 0};

  int          tx_gap        = 0;
  bit          tx_steady     = 1'b0;
  int          rx_stall      = 0;
  int          rx_hold       = 0;
  bit          rx_steady     = 1'b0;
  logic        rx_hold_start = 1'b0;

  stop_wait_command_sender #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .cmd       (cmd),
    .param     (param),
    .empty     (empty),
    .pop       (pop),
    .event_res (event_res),
    .out_cmd   (out_cmd),
    .out_param (out_param),
    .attempt   (attempt),
    .pending   (pending),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d results still due, %0d items not taken", due_events.size(),
             n_queued - n_accepted);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void note_result(event_t ev, logic [7:0] c, logic [7:0] p,
                                      logic [3:0] att);
    result_t r;
    r.ev      = ev;
    r.cmd     = c;
    r.param   = p;
    r.attempt = att;
    // pending is taken after the state change of the event
    r.pending = 5'(waiting_cmds.size() + (in_flight ? 1 : 0));
    r.last    = 1'b0;
    due_events.push_back(r);
    n_new++;
  endfunction

  function automatic void launch_frame();
    in_flight  = 1'b1;
    ticks_left = cfg_timeout;
    note_result(EV_SEND, fl_opcode, fl_param, 4'd0);
  endfunction

  function automatic void start_next();
    logic [15:0] head;
    if (in_flight || waiting_cmds.size() == 0) return;
    head       = waiting_cmds.pop_front();
    fl_opcode  = head[15:8];
    fl_param   = head[7:0];
    sends_done = '0;
    launch_frame();
  endfunction

  function automatic void arq_step(action_t act, logic [7:0] c, logic [7:0] p);
    result_t tail;
    n_new = 0;
    case (act)
      ACT_ENQUEUE: begin
        if (waiting_cmds.size() >= QDEPTH) note_result(EV_DROPPED, c, p, 4'd0);
        else waiting_cmds.push_back({c, p});
        start_next();
      end
      ACT_ACK: begin
        // acks for another opcode or with nothing in flight are ignored
        if (in_flight && c == fl_opcode) begin
          in_flight  = 1'b0;
          ticks_left = '0;
          note_result(EV_ACKED, c, p, 4'd0);
          start_next();
        end
      end
      ACT_TICK: begin
        if (in_flight) begin
          if (ticks_left > 16'd1) begin
            ticks_left--;
          end else begin
            ticks_left = '0;
            sends_done = sends_done + 4'd1;
            // zero attempts behaves like one
            if (sends_done >= cfg_attempts || sends_done == 4'd0) begin
              in_flight = 1'b0;
              note_result(EV_GAVE_UP, fl_opcode, fl_param, 4'd0);
              start_next();
            end else begin
              note_result(EV_RETRY, fl_opcode, fl_param, sends_done + 4'd1);
              launch_frame();
            end
          end
        end
      end
      default: begin
        waiting_cmds.delete();
        in_flight  = 1'b0;
        ticks_left = '0;
      end
    endcase
    if (n_new > 0) begin
      tail      = due_events.pop_back();
      tail.last = 1'b1;
      due_events.push_back(tail);
    end
  endfunction

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : item_driver
    item_t nxt;
    logic  take;
    take = push && !full;
    if (push && full) n_full_cycles++;
    if (take) begin
      arq_step(action_t'(action), cmd, param);
      n_accepted++;
      tx_gap = tx_steady ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
    end
    if (rst) begin
      push <= 1'b0;
    end else if (take || !push) begin
      if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        action <= nxt.action;
        cmd    <= nxt.cmd;
        param  <= nxt.param;
        push   <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t want;
    logic    take;
    take = pop && !empty;
    if (take) begin
      n_checked++;
      if (due_events.size() == 0) begin
        $display("%0t: unexpected transaction, event %0d cmd %0d param %0d", $time,
                 event_res, out_cmd, out_param);
        n_errors++;
      end else begin
        want = due_events.pop_front();
        n_ev[int'(want.ev)]++;
        cmp_field("event_res", want.ev, event_res);
        cmp_field("out_cmd", want.cmd, out_cmd);
        cmp_field("out_param", want.param, out_param);
        cmp_field("attempt", want.attempt, attempt);
        cmp_field("pending", want.pending, pending);
        cmp_field("last", want.last, last);
      end
      rx_stall = rx_steady ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
    end
    if (rx_hold_start) rx_hold = RX_HOLD_CYCLES;
    if (rst) begin
      pop <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      pop <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic add_item(action_t a, logic [7:0] c, logic [7:0] p);
    item_t it;
    it.action = a;
    it.cmd    = c;
    it.param  = p;
    pending_items.push_back(it);
    n_queued++;
  endtask

  // mostly well-formed traffic: acks follow the order of enqueued opcodes, opcodes
  // come often from a small pool so late acks still tend to match
  task automatic add_random(int n, int w_enq, int w_ack, int w_tick);
    item_t it;
    int    r;
    repeat (n) begin
      r        = $urandom_range(0, 99);
      it.cmd   = 8'($urandom);
      it.param = 8'($urandom);
      if (r < w_enq) begin
        it.action = ACT_ENQUEUE;
        if ($urandom_range(0, 1) == 1) it.cmd = op_pool[$urandom_range(0, 3)];
        if (gen_order.size() <= QDEPTH) gen_order.push_back(it.cmd);
      end else if (r < w_enq + w_ack) begin
        it.action = ACT_ACK;
        if (gen_order.size() > 0 && $urandom_range(0, 3) != 0) it.cmd = gen_order.pop_front();
      end else if (r < w_enq + w_ack + w_tick) begin
        it.action = ACT_TICK;
      end else begin
        it.action = ACT_CLOSE;
        gen_order.delete();
      end
      pending_items.push_back(it);
      n_queued++;
    end
  endtask

  // bench waits until every result is in, then lets the engine drain items
  // that cause no result
  task automatic wait_idle();
    do @(negedge clk); while (n_accepted != n_queued || due_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TIMEOUT) cfg_timeout = val;
    else if (idx == REG_MAX_ATTEMPTS) cfg_attempts = val[3:0];
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int i;
    int j;
    for (j = 0; j < 4; j++) op_pool[j] = 8'($urandom);
    wait (!rst);

    // reset settings first: long timeout, three attempts
    add_random(50, 50, 40, 8);
    wait_idle();

    write_reg(REG_TIMEOUT, 16'd1);
    write_reg(REG_MAX_ATTEMPTS, 16'd2);
    add_item(ACT_ENQUEUE, 8'h00, 8'h00);
    add_item(ACT_ACK, 8'h01, 8'h5A);        // wrong opcode
    add_item(ACT_ACK, 8'h00, 8'hFF);
    add_item(ACT_ACK, 8'h00, 8'h00);        // nothing in flight
    add_item(ACT_TICK, 8'hFF, 8'hFF);       // idle tick
    add_item(ACT_ENQUEUE, 8'hFF, 8'hFF);
    add_item(ACT_TICK, 8'h00, 8'h00);       // retry
    add_item(ACT_TICK, 8'h00, 8'h00);       // give up
    // one in flight, sixteen queued, the last one dropped
    for (j = 0; j < 18; j++) add_item(ACT_ENQUEUE, 8'(j * 15), 8'(255 - j * 13));
    add_item(ACT_CLOSE, 8'hFF, 8'hFF);
    wait_idle();

    for (i = 0; i < NUM_PHASES; i++) begin
      write_reg(REG_TIMEOUT, 16'(ph_timeout[i]));
      write_reg(REG_MAX_ATTEMPTS, {12'($urandom), 4'(ph_attempts[i])});
      for (j = 0; j < 4; j++) op_pool[j] = 8'($urandom);
      gen_order.delete();
      add_random(ph_items[i], ph_enq[i], ph_ack[i], ph_tick[i]);
      if (i == 0) begin
        // stall the result side long enough to back the block up into full
        @(posedge clk);
        rx_hold_start <= 1'b1;
        @(posedge clk);
        rx_hold_start <= 1'b0;
      end
      wait_idle();
    end

    $display("%0d items under %0d register settings, %0d results checked, input full %0d cycles",
             n_accepted, NUM_PHASES + 2, n_checked, n_full_cycles);
    $display("events: send %0d, acked %0d, gave up %0d, retry %0d, dropped %0d",
             n_ev[0], n_ev[1], n_ev[2], n_ev[3], n_ev[4]);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### stop_wait_command_sender.f
hw/rtl/swcs_pkg.sv
hw/rtl/swcs_front.sv
hw/rtl/swcs_engine.sv
hw/rtl/swcs_resq.sv
hw/rtl/stop_wait_command_sender.sv
hw/rtl/swcs_checker.sv
test/stop_wait_command_sender_tb.sv
